@@ src/htw_pkg.sv @@
package htw_pkg;

   typedef logic [31:0] word_type;

   // node payload as held in the node RAM: expiry, handle, session
   typedef struct packed {
      word_type expiry;
      word_type handle;
      word_type session;
   } node_type;

   localparam int NODE_BITS = $bits(node_type);

   // cap on firings per tick
   localparam int MAX_RESULTS = 64;
   localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

endpackage

@@ src/htw_ram.sv @@
module htw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ src/htw_slot_calc.sv @@
module htw_slot_calc
   import htw_pkg::*;
#(
   parameter int NEAR_BITS   = 8,
   parameter int LEVEL_BITS  = 6,
   parameter int LEVEL_COUNT = 4,
   parameter int BKT_W       = 9
) (
   input  word_type         expiry,
   input  word_type         tick,
   output logic [BKT_W-1:0] bucket
);

   localparam int NEAR_SLOTS  = 1 << NEAR_BITS;
   localparam int LEVEL_SLOTS = (1 << LEVEL_BITS) - 1;

   logic [63:0] e64;
   logic [63:0] t64;
   logic [63:0] sel;
   int          lvl;
   logic        hit;
   int          slot;

   assign e64 = {32'd0, expiry};
   assign t64 = {32'd0, tick};

   always_comb begin
      lvl = LEVEL_COUNT - 1;
      hit = 1'b0;
      for (int l = 0; l < LEVEL_COUNT - 1; l++) begin
         if (!hit && ((e64 >> (NEAR_BITS + LEVEL_BITS * (l + 1))) ==
                      (t64 >> (NEAR_BITS + LEVEL_BITS * (l + 1))))) begin
            hit = 1'b1;
            lvl = l;
         end
      end
      sel  = (e64 >> (NEAR_BITS + LEVEL_BITS * lvl)) & 64'(LEVEL_SLOTS);
      // index zero wraps to the top slot
      slot = (sel == 64'd0) ? (LEVEL_SLOTS - 1) : (int'(sel[31:0]) - 1);
      if ((e64 >> NEAR_BITS) == (t64 >> NEAR_BITS)) begin
         bucket = BKT_W'(expiry & word_type'(NEAR_SLOTS - 1));
      end else begin
         bucket = BKT_W'(NEAR_SLOTS + lvl * LEVEL_SLOTS + slot);
      end
   end

endmodule

@@ src/hierarchical_timer_wheel.sv @@
// Hierarchical timing wheel, one transfer at a time under a small sequencer.
// Add: immediate/dropped result valid the cycle after accept, ready again once it is
//   taken; a stored add passes ADD_RD, PLACE and PL_WR before the next accept.
// Tick: reads the near bucket, emits each fired node (stalled by the output), may
//   cascade and re-place nodes; bucket and node RAMs serve one read a cycle.
// Reset: synchronous; a clear pass writes every bucket empty.
module hierarchical_timer_wheel
   import htw_pkg::*;
#(
   parameter int NEAR_BITS     = 8,
   parameter int LEVEL_BITS    = 6,
   parameter int LEVEL_COUNT   = 4,
   parameter int NODE_CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // delay_ticks[30:0], target_handle[62:31], session_id[94:63], zero pad
   input  logic [95:0] req_tdata,
   // kind[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // fired_handle[31:0], fired_session[63:32], dropped[64], zero pad
   output logic [71:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int NEAR_SLOTS  = 1 << NEAR_BITS;
   localparam int LEVEL_SLOTS = (1 << LEVEL_BITS) - 1;
   localparam int BUCKETS     = NEAR_SLOTS + LEVEL_COUNT * LEVEL_SLOTS;
   localparam int BKT_W       = $clog2(BUCKETS);
   localparam int NODE_W      = $clog2(NODE_CAPACITY);
   localparam int IDX_W       = $clog2(NODE_CAPACITY + 1);
   localparam int FCNT_W      = IDX_W;
   localparam logic [IDX_W-1:0] NIL = IDX_W'(NODE_CAPACITY);

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_ADD_RD   = 4'd2;
   localparam logic [3:0] ST_PLACE    = 4'd3;
   localparam logic [3:0] ST_PL_WR    = 4'd4;
   localparam logic [3:0] ST_TK_RD    = 4'd5;
   localparam logic [3:0] ST_TK_HD    = 4'd6;
   localparam logic [3:0] ST_TK_NODE  = 4'd7;
   localparam logic [3:0] ST_TK_ND    = 4'd8;
   localparam logic [3:0] ST_OUT      = 4'd9;
   localparam logic [3:0] ST_TK_FIN   = 4'd10;
   localparam logic [3:0] ST_CAS_CHK  = 4'd11;
   localparam logic [3:0] ST_CAS_HD   = 4'd12;
   localparam logic [3:0] ST_CAS_NODE = 4'd13;
   localparam logic [3:0] ST_CAS_ND   = 4'd14;

   // control state
   logic [3:0]        state_ff, state_in;
   logic [3:0]        ret_ff, ret_in;
   logic [BKT_W-1:0]  clr_ff, clr_in;
   word_type          tick_ff, tick_in;
   logic [FCNT_W-1:0] fcnt_ff, fcnt_in;
   // lowest free-list slot ever pushed; slots below it still hold reset order
   logic [FCNT_W-1:0] wmark_ff, wmark_in;
   logic [RCNT_W-1:0] rcnt_ff, rcnt_in;
   // payload
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [IDX_W-1:0]  keep_tail_ff, keep_tail_in;
   logic [NODE_W-1:0] pn_ff, pn_in;
   word_type          pe_ff, pe_in;
   word_type          hold_h_ff, hold_h_in;
   word_type          hold_s_ff, hold_s_in;
   word_type          rh_ff, rh_in;
   word_type          rs_ff, rs_in;
   logic              rd_ff, rd_in;
   logic              rl_ff, rl_in;

   // RAM ports
   logic                 bk_we;
   logic [BKT_W-1:0]     bk_wa, bk_ra;
   logic [2*IDX_W-1:0]   bk_wd, bk_rd;
   logic                 nd_we;
   logic [NODE_W-1:0]    nd_wa, nd_ra;
   node_type             nd_wd, nd_rd;
   logic                 nx_we;
   logic [NODE_W-1:0]    nx_wa;
   logic [IDX_W-1:0]     nx_wd, nx_rd;
   logic                 fl_we;
   logic [NODE_W-1:0]    fl_wa, fl_ra;
   logic [NODE_W-1:0]    fl_wd, fl_rd;

   logic [BKT_W-1:0]  place_b;
   logic [BKT_W-1:0]  near_b;
   logic [BKT_W-1:0]  cas_b;
   logic              cas_hit;
   logic [IDX_W-1:0]  bk_head, bk_tail;
   logic [FCNT_W-1:0] pop_idx;
   logic [NODE_W-1:0] pop_node;

   htw_ram #(.WIDTH(2*IDX_W), .DEPTH(BUCKETS)) u_bucket_ram (
      .clock(clock), .wr_en(bk_we), .wr_addr(bk_wa), .wr_data(bk_wd),
      .rd_addr(bk_ra), .rd_data(bk_rd));
   htw_ram #(.WIDTH(NODE_BITS), .DEPTH(NODE_CAPACITY)) u_node_ram (
      .clock(clock), .wr_en(nd_we), .wr_addr(nd_wa), .wr_data(nd_wd),
      .rd_addr(nd_ra), .rd_data(nd_rd));
   htw_ram #(.WIDTH(IDX_W), .DEPTH(NODE_CAPACITY)) u_next_ram (
      .clock(clock), .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
      .rd_addr(nd_ra), .rd_data(nx_rd));
   htw_ram #(.WIDTH(NODE_W), .DEPTH(NODE_CAPACITY)) u_free_ram (
      .clock(clock), .wr_en(fl_we), .wr_addr(fl_wa), .wr_data(fl_wd),
      .rd_addr(fl_ra), .rd_data(fl_rd));

   // shared slot-selection unit, used by adds and by every cascaded node
   htw_slot_calc #(
      .NEAR_BITS(NEAR_BITS), .LEVEL_BITS(LEVEL_BITS),
      .LEVEL_COUNT(LEVEL_COUNT), .BKT_W(BKT_W)
   ) u_slot_calc (
      .expiry(pe_ff), .tick(tick_ff), .bucket(place_b));

   assign bk_head = bk_rd[2*IDX_W-1:IDX_W];
   assign bk_tail = bk_rd[IDX_W-1:0];
   assign near_b  = BKT_W'(tick_ff & word_type'(NEAR_SLOTS - 1));
   assign pop_idx = fcnt_ff - FCNT_W'(1);
   // untouched free-list slots hold the reset order CAP-1-k
   assign pop_node = (pop_idx < wmark_ff) ?
                     NODE_W'(FCNT_W'(NODE_CAPACITY - 1) - pop_idx) : fl_rd;

   // cascade: first level (after the tick) whose lower bits are all zero
   // and whose own index is nonzero
   always_comb begin
      logic [63:0] t64;
      logic [63:0] idx;
      logic        stop;
      t64     = {32'd0, tick_ff};
      stop    = 1'b0;
      cas_hit = 1'b0;
      cas_b   = '0;
      for (int l = 0; l < LEVEL_COUNT; l++) begin
         idx = (t64 >> (NEAR_BITS + LEVEL_BITS * l)) & 64'(LEVEL_SLOTS);
         if (!stop) begin
            if ((t64 & ((64'd1 << (NEAR_BITS + LEVEL_BITS * l)) - 64'd1)) != 64'd0) begin
               stop = 1'b1;
            end else if (idx != 64'd0) begin
               stop    = 1'b1;
               cas_hit = 1'b1;
               cas_b   = BKT_W'(NEAR_SLOTS + l * LEVEL_SLOTS + int'(idx[31:0]) - 1);
            end
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {7'd0, rd_ff, rs_ff, rh_ff};
   assign rsp_tlast  = rl_ff;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      clr_in       = clr_ff;
      tick_in      = tick_ff;
      fcnt_in      = fcnt_ff;
      wmark_in     = wmark_ff;
      rcnt_in      = rcnt_ff;
      cur_in       = cur_ff;
      keep_tail_in = keep_tail_ff;
      pn_in        = pn_ff;
      pe_in        = pe_ff;
      hold_h_in    = hold_h_ff;
      hold_s_in    = hold_s_ff;
      rh_in        = rh_ff;
      rs_in        = rs_ff;
      rd_in        = rd_ff;
      rl_in        = rl_ff;
      bk_we = 1'b0; bk_wa = place_b; bk_wd = {NIL, NIL}; bk_ra = place_b;
      nd_we = 1'b0; nd_wa = pop_node; nd_ra = cur_ff[NODE_W-1:0];
      nd_wd = '{expiry: pe_ff, handle: hold_h_ff, session: hold_s_ff};
      nx_we = 1'b0; nx_wa = pn_ff; nx_wd = NIL;
      fl_we = 1'b0; fl_wa = fcnt_ff[NODE_W-1:0];
      fl_wd = cur_ff[NODE_W-1:0]; fl_ra = pop_idx[NODE_W-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            bk_we  = 1'b1;
            bk_wa  = clr_ff;
            clr_in = clr_ff + BKT_W'(1);
            if (clr_ff == BKT_W'(BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               hold_h_in = req_tdata[62:31];
               hold_s_in = req_tdata[94:63];
               pe_in     = tick_ff + {1'b0, req_tdata[30:0]};
               rcnt_in   = '0;
               if (req_tuser[0] == 1'b0) begin
                  state_in = ST_TK_RD;
               end else if (req_tdata[30:0] == 31'd0 || fcnt_ff == '0) begin
                  rh_in    = req_tdata[62:31];
                  rs_in    = req_tdata[94:63];
                  rd_in    = (req_tdata[30:0] != 31'd0);
                  rl_in    = 1'b1;
                  ret_in   = ST_IDLE;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_ADD_RD;
               end
            end
         end
         ST_ADD_RD: begin
            nd_we    = 1'b1;
            fcnt_in  = pop_idx;
            pn_in    = pop_node;
            ret_in   = ST_IDLE;
            state_in = ST_PLACE;
         end
         ST_PLACE: begin
            // bucket read issued; terminate this node's link
            nx_we    = 1'b1;
            state_in = ST_PL_WR;
         end
         ST_PL_WR: begin
            bk_we = 1'b1;
            if (bk_head == NIL) begin
               bk_wd = {IDX_W'(pn_ff), IDX_W'(pn_ff)};
            end else begin
               bk_wd = {bk_head, IDX_W'(pn_ff)};
               nx_we = 1'b1;
               nx_wa = bk_tail[NODE_W-1:0];
               nx_wd = IDX_W'(pn_ff);
            end
            state_in = ret_ff;
         end
         ST_TK_RD: begin
            bk_ra    = near_b;
            state_in = ST_TK_HD;
         end
         ST_TK_HD: begin
            cur_in       = bk_head;
            keep_tail_in = bk_tail;
            state_in     = ST_TK_NODE;
         end
         ST_TK_NODE: begin
            if (cur_ff == NIL || rcnt_ff == RCNT_W'(MAX_RESULTS)) begin
               state_in = ST_TK_FIN;
            end else begin
               state_in = ST_TK_ND;
            end
         end
         ST_TK_ND: begin
            rh_in   = nd_rd.handle;
            rs_in   = nd_rd.session;
            rd_in   = 1'b0;
            rl_in   = (nx_rd == NIL) || (rcnt_ff == RCNT_W'(MAX_RESULTS - 1));
            rcnt_in = rcnt_ff + RCNT_W'(1);
            if (fcnt_ff < FCNT_W'(NODE_CAPACITY)) begin
               fl_we   = 1'b1;
               fcnt_in = fcnt_ff + FCNT_W'(1);
               if (fcnt_ff < wmark_ff) begin
                  wmark_in = fcnt_ff;
               end
            end
            cur_in   = nx_rd;
            ret_in   = ST_TK_NODE;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ret_ff;
            end
         end
         ST_TK_FIN: begin
            bk_we    = 1'b1;
            bk_wa    = near_b;
            bk_wd    = {cur_ff, (cur_ff == NIL) ? NIL : keep_tail_ff};
            tick_in  = tick_ff + 32'd1;
            state_in = ST_CAS_CHK;
         end
         ST_CAS_CHK: begin
            bk_ra    = cas_b;
            state_in = cas_hit ? ST_CAS_HD : ST_IDLE;
         end
         ST_CAS_HD: begin
            bk_we    = 1'b1;
            bk_wa    = cas_b;
            cur_in   = bk_head;
            state_in = ST_CAS_NODE;
         end
         ST_CAS_NODE: begin
            state_in = (cur_ff == NIL) ? ST_IDLE : ST_CAS_ND;
         end
         ST_CAS_ND: begin
            pe_in    = nd_rd.expiry;
            pn_in    = cur_ff[NODE_W-1:0];
            cur_in   = nx_rd;
            ret_in   = ST_CAS_NODE;
            state_in = ST_PLACE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ret_ff   <= ST_IDLE;
         clr_ff   <= '0;
         tick_ff  <= '0;
         fcnt_ff  <= FCNT_W'(NODE_CAPACITY);
         wmark_ff <= FCNT_W'(NODE_CAPACITY);
         rcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         clr_ff   <= clr_in;
         tick_ff  <= tick_in;
         fcnt_ff  <= fcnt_in;
         wmark_ff <= wmark_in;
         rcnt_ff  <= rcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      keep_tail_ff <= keep_tail_in;
      pn_ff        <= pn_in;
      pe_ff        <= pe_in;
      hold_h_ff    <= hold_h_in;
      hold_s_ff    <= hold_s_in;
      rh_ff        <= rh_in;
      rs_ff        <= rs_in;
      rd_ff        <= rd_in;
      rl_ff        <= rl_in;
   end

   // free count never exceeds the pool
   a_fcnt_bound: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff <= FCNT_W'(NODE_CAPACITY))
      else $error("free count above pool size");

   // a dropped result only for an add, and always the last of its item
   a_drop_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[64] |-> rsp_tlast && ret_ff == ST_IDLE)
      else $error("dropped result not final");

   // tick count moves only at the end of a tick walk
   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      (tick_ff != $past(tick_ff)) |-> $past(state_ff) == ST_TK_FIN)
      else $error("tick count changed outside tick finish");

endmodule
